FILE: design/rel_pkg.sv
// ----------------------------------------------------------------------------
// rel_pkg
// Shared types and constants of the ring event log: command and result
// codes, field widths and the default ring size.
// ----------------------------------------------------------------------------
package rel_pkg;

  // field widths
  localparam int unsigned CmdW   = 2;
  localparam int unsigned KindW  = 2;
  localparam int unsigned SeqW   = 16;
  localparam int unsigned CodeW  = 8;
  localparam int unsigned CountW = 16;

  // one stored word: sequence over code
  localparam int unsigned RecW = SeqW + CodeW;

  // default ring size
  localparam int unsigned SlotsDefault = 16;

  // input commands; the fourth code means nothing and is ignored
  typedef enum logic [CmdW-1:0] {
    CMD_LOG  = 2'd0,
    CMD_DUMP = 2'd1,
    CMD_WIPE = 2'd2
  } cmd_e;

  // result kinds
  typedef enum logic [KindW-1:0] {
    KIND_LOG_ACK  = 2'd0,
    KIND_HEADER   = 2'd1,
    KIND_RECORD   = 2'd2,
    KIND_WIPE_ACK = 2'd3
  } kind_e;

endpackage

FILE: design/rel_ram.sv
// ----------------------------------------------------------------------------
// rel_ram
// Generic single-clock RAM: one write port, one read port, read data
// registered, so it appears in the cycle after the read enable.
// ----------------------------------------------------------------------------
module rel_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/ring_event_log_core.sv
// A command's first result word shows in the cycle after it is accepted.
// Log, wipe and an empty dump never hold busy; a dump of valid slots holds busy while
//   the header and then one record a cycle go out, and takes no new command till then.
// Results go out on the strobe and cannot be stalled by the receiver.
// Reset (rst_ni low, asynchronous) empties the log: fill count, slot pointer and
//   lifetime count go to zero; the slot RAM is not cleared.
// ----------------------------------------------------------------------------
// ring_event_log_core
// Ring of log slots that overwrites the oldest entry. Sequence and code of
// each slot live in one RAM; a fill count stands in for per-slot valid marks,
// since valid slots always form a run that ends just before the next slot.
// ----------------------------------------------------------------------------
module ring_event_log_core
  import rel_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [CmdW-1:0]   command_i,
  input  logic [CodeW-1:0]  event_code_i,
  output logic              strobe_o,
  output logic [KindW-1:0]  kind_o,
  output logic [SeqW-1:0]   sequence_res_o,
  output logic [CodeW-1:0]  code_out_o,
  output logic [CountW-1:0] lifetime_count_o,
  output logic              last_o
);

  localparam int unsigned AddrW = $clog2(SLOTS);
  localparam int unsigned FillW = $clog2(SLOTS + 1);
  localparam logic [AddrW-1:0] LastSlot = AddrW'(SLOTS - 1);
  localparam logic [FillW-1:0] FullFill = FillW'(SLOTS);

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  state_e             state_q;
  logic [AddrW-1:0]   ptr_q;
  logic [FillW-1:0]   fill_q;
  logic [CountW-1:0]  count_q;

  // dump read walker
  logic [AddrW-1:0]   rd_ptr_q;
  logic [FillW-1:0]   rd_left_q;
  logic               rd_pend_q;
  logic               rd_last_q;

  // registered result word for acks and headers
  logic               out_valid_q;
  kind_e              kind_q;
  logic [SeqW-1:0]    seq_q;
  logic [CountW-1:0]  cnt_q;
  logic               last_q;

  logic               accept;
  logic               do_log;
  logic               rd_en;
  logic [RecW-1:0]    rd_data;
  logic [CountW-1:0]  count_inc;
  logic [AddrW-1:0]   ptr_inc;
  logic [AddrW-1:0]   dump_start;

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign do_log    = accept && (command_i == CMD_LOG);
  assign rd_en     = (state_q == ST_DUMP) && (rd_left_q != '0);
  assign count_inc = count_q + CountW'(1);
  assign ptr_inc   = (ptr_q == LastSlot) ? '0 : ptr_q + AddrW'(1);
  // oldest slot: the next one once the ring is full, else slot zero
  assign dump_start = (fill_q == FullFill) ? ptr_q : '0;

  // slot storage: {sequence, code}
  rel_ram #(
    .Width (RecW),
    .Depth (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (do_log),
    .waddr_i (ptr_q),
    .wdata_i ({count_q, event_code_i}),
    .re_i    (rd_en),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_data)
  );

  // control state, walker and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      fill_q      <= '0;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      rd_left_q   <= '0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_LOG_ACK;
      seq_q       <= '0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      out_valid_q <= 1'b0;
      rd_pend_q   <= rd_en;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (command_i)
              CMD_LOG: begin
                ptr_q       <= ptr_inc;
                count_q     <= count_inc;
                if (fill_q != FullFill) begin
                  fill_q <= fill_q + FillW'(1);
                end
                out_valid_q <= 1'b1;
                kind_q      <= KIND_LOG_ACK;
                seq_q       <= count_q;
                cnt_q       <= count_inc;
                last_q      <= 1'b1;
              end
              CMD_DUMP: begin
                out_valid_q <= 1'b1;
                kind_q      <= KIND_HEADER;
                seq_q       <= '0;
                cnt_q       <= count_q;
                last_q      <= (fill_q == '0);
                rd_ptr_q    <= dump_start;
                rd_left_q   <= fill_q;
                if (fill_q != '0) begin
                  state_q <= ST_DUMP;
                end
              end
              CMD_WIPE: begin
                ptr_q       <= '0;
                fill_q      <= '0;
                count_q     <= '0;
                out_valid_q <= 1'b1;
                kind_q      <= KIND_WIPE_ACK;
                seq_q       <= '0;
                cnt_q       <= '0;
                last_q      <= 1'b1;
              end
              default: begin
                // unused code: no result, no change
              end
            endcase
          end
        end
        ST_DUMP: begin
          // issue one read a cycle, wrapping round the ring
          if (rd_en) begin
            rd_ptr_q  <= (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + AddrW'(1);
            rd_left_q <= rd_left_q - FillW'(1);
            rd_last_q <= (rd_left_q == FillW'(1));
          end
          // final record on the ports this cycle
          if (rd_pend_q && (rd_left_q == '0)) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // result ports: registered word, or a record straight from the RAM register
  assign strobe_o         = out_valid_q || rd_pend_q;
  assign kind_o           = rd_pend_q ? KIND_RECORD : kind_q;
  assign sequence_res_o   = rd_pend_q ? rd_data[RecW-1:CodeW] : seq_q;
  assign code_out_o       = rd_pend_q ? rd_data[CodeW-1:0] : '0;
  assign lifetime_count_o = rd_pend_q ? count_q : cnt_q;
  assign last_o           = rd_pend_q ? rd_last_q : last_q;

`ifndef NO_ASSERTIONS
  // acks/headers and records never share a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_q && rd_pend_q))
    else $error("result word and record collide");

  // a read is only in flight during a dump
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == ST_DUMP))
    else $error("record read outside dump");

  // the walker is spent whenever the block is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (rd_left_q == '0))
    else $error("walker left slots behind");

  // a dump of an empty log is one header marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (command_i == CMD_DUMP) && (fill_q == '0)) |=>
      (strobe_o && last_o && !busy))
    else $error("empty dump not closed by its header");

  // a log is acknowledged in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_log |=> (strobe_o && (kind_o == KIND_LOG_ACK) && last_o))
    else $error("log not acknowledged");
`endif

endmodule
